// ===== design/rgbkf_pkg.sv =====
// ----------------------------------------------------------------------------
// RGB 3x3 kernel filter package
// Shared types, register codes, filter modes and kernel lookups.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rgbkf_pkg;

    // Image geometry and widths.
    localparam int POS_W      = 8;
    localparam int CH_W       = 8;
    localparam int PIX_W      = 3 * CH_W;
    localparam int CFG_W      = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int ADDR_W     = 2 * POS_W;
    localparam int MEM_DEPTH  = 1 << ADDR_W;
    localparam logic [CFG_W-1:0] MAX_WIDTH  = CFG_W'(256);
    localparam logic [CFG_W-1:0] MAX_HEIGHT = CFG_W'(256);

    // Kernel walk: nine taps, one per cycle.
    localparam int TAP_W = 4;
    localparam logic [TAP_W-1:0] LAST_TAP   = TAP_W'(8);
    localparam logic [TAP_W-1:0] CENTER_TAP = TAP_W'(4);
    localparam int WGT_W = 5;
    localparam int ACC_W = 14;
    localparam int BLUR_SHIFT = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

    // Filter modes; the unused code behaves as identity.
    localparam logic [1:0] MODE_IDENTITY = 2'd0;
    localparam logic [1:0] MODE_SHARPEN  = 2'd1;
    localparam logic [1:0] MODE_BLUR     = 2'd2;

    // Request kinds.
    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_FILTER = 1'b1;

    typedef struct packed {
        logic             kind;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [CH_W-1:0]  pixel_red;
        logic [CH_W-1:0]  pixel_green;
        logic [CH_W-1:0]  pixel_blue;
    } t_in_req;

    typedef struct packed {
        logic [POS_W-1:0] out_x;
        logic [POS_W-1:0] out_y;
        logic [CH_W-1:0]  filtered_red;
        logic [CH_W-1:0]  filtered_green;
        logic [CH_W-1:0]  filtered_blue;
    } t_out_res;

    // Control from the sequencer to the accumulator.
    typedef struct packed {
        logic                    clear;
        logic                    add;
        logic                    blur;
        logic signed [WGT_W-1:0] weight;
    } t_acc_ctrl;

    // Kernel weight of one tap under a filter mode.
    function automatic logic signed [WGT_W-1:0] tap_weight(
        input logic [1:0]       mode,
        input logic [TAP_W-1:0] tap
    );
        logic signed [WGT_W-1:0] w;
        w = '0;
        unique case (mode)
            MODE_SHARPEN: begin
                w = (tap == CENTER_TAP) ? WGT_W'(9) : -WGT_W'(1);
            end
            MODE_BLUR: begin
                unique case (tap)
                    4'd0, 4'd2, 4'd6, 4'd8: w = WGT_W'(1);
                    4'd1, 4'd3, 4'd5, 4'd7: w = WGT_W'(2);
                    4'd4:                   w = WGT_W'(4);
                    default:                w = '0;
                endcase
            end
            default: begin
                w = (tap == CENTER_TAP) ? WGT_W'(1) : '0;
            end
        endcase
        return w;
    endfunction

    // Column offset of a tap: -1, 0 or +1.
    function automatic logic signed [1:0] tap_dx(input logic [TAP_W-1:0] tap);
        logic signed [1:0] d;
        unique case (tap)
            4'd0, 4'd3, 4'd6: d = -2'sd1;
            4'd2, 4'd5, 4'd8: d = 2'sd1;
            default:          d = 2'sd0;
        endcase
        return d;
    endfunction

    // Row offset of a tap: -1, 0 or +1.
    function automatic logic signed [1:0] tap_dy(input logic [TAP_W-1:0] tap);
        logic signed [1:0] d;
        unique case (tap)
            4'd0, 4'd1, 4'd2: d = -2'sd1;
            4'd6, 4'd7, 4'd8: d = 2'sd1;
            default:          d = 2'sd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== design/rgb_3x3_kernel_filter_core.sv =====
// Loads give no result; the next request is taken the cycle after.
// A filter request occupies the block from acceptance through the read, drain and
// finish states: nine taps are read one per cycle from the single-port pixel
// memory; a result still held on a stalled output port delays the answer until it is
// taken. Requests outside the image are taken without a walk and give no result.
// Reset is synchronous and active low; it restores the filter registers to their
// defaults and empties the output; the pixel memory keeps its contents.
// ----------------------------------------------------------------------------
// RGB 3x3 kernel filter core
// Pixel memory with a nine-tap sequencer for identity, sharpen and blur.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgb_3x3_kernel_filter_core
    import rgbkf_pkg::*;
(
    input  wire  logic                 i_clk,
    input  wire  logic                 i_rst_n,
    input  wire  logic                 i_in_valid,
    output logic                       o_in_stall,
    input  wire  t_in_req              i_in_data,
    output logic                       o_out_valid,
    input  wire  logic                 i_out_stall,
    output t_out_res                   o_out_data,
    input  wire  logic                 i_cfg_we,
    input  wire  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire  logic [CFG_W-1:0]     i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DRAIN,
        S_FINISH
    } t_state;

    t_state            r_state;
    logic [1:0]        r_filter_mode;
    logic [CFG_W-1:0]  r_image_width;
    logic [CFG_W-1:0]  r_image_height;
    logic [1:0]        r_mode;
    logic [POS_W-1:0]  r_x;
    logic [POS_W-1:0]  r_y;
    logic [TAP_W-1:0]  r_tap;
    logic              r_rd_ok;
    logic signed [WGT_W-1:0] r_rd_weight;
    logic              r_out_valid;
    t_out_res          r_out_data;

    logic [CFG_W-1:0]  width_eff;
    logic [CFG_W-1:0]  height_eff;
    logic              in_accept;
    logic              in_inside;
    logic signed [1:0] dx_off;
    logic signed [1:0] dy_off;
    logic [CFG_W-1:0]  tap_px;
    logic [CFG_W-1:0]  tap_py;
    logic signed [WGT_W-1:0] tap_w;
    logic              tap_ok;
    logic              out_free;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [PIX_W-1:0]  mem_rdata;
    logic [PIX_W-1:0]  acc_result;
    t_acc_ctrl         acc_ctrl;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_mode  <= MODE_IDENTITY;
            r_image_width  <= MAX_WIDTH;
            r_image_height <= MAX_HEIGHT;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_FILTER_MODE) begin
                r_filter_mode <= i_cfg_data[1:0];
            end
            if (i_cfg_index == CFG_IMAGE_WIDTH) begin
                r_image_width <= i_cfg_data;
            end
            if (i_cfg_index == CFG_IMAGE_HEIGHT) begin
                r_image_height <= i_cfg_data;
            end
        end
    end

    // Effective image size, limited to the memory geometry.
    assign width_eff  = (r_image_width > MAX_WIDTH) ? MAX_WIDTH : r_image_width;
    assign height_eff = (r_image_height > MAX_HEIGHT) ? MAX_HEIGHT : r_image_height;

    // Input handshake: requests are taken only between filter walks.
    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign in_inside  = ({1'b0, i_in_data.pos_x} < width_eff) &&
                        ({1'b0, i_in_data.pos_y} < height_eff);

    // Neighbor position of the current tap; a step off either edge wraps
    // to a value at or above the image size and so lands outside.
    assign dx_off = tap_dx(r_tap);
    assign dy_off = tap_dy(r_tap);
    assign tap_px = {1'b0, r_x} + {{(CFG_W-2){dx_off[1]}}, dx_off};
    assign tap_py = {1'b0, r_y} + {{(CFG_W-2){dy_off[1]}}, dy_off};
    assign tap_w  = tap_weight(r_mode, r_tap);
    assign tap_ok = (tap_px < width_eff) && (tap_py < height_eff) && (tap_w != '0);

    // Memory port: loads write in the accept cycle, taps read during the walk.
    assign mem_we   = in_accept && in_inside && (i_in_data.kind == KIND_LOAD);
    assign mem_addr = (r_state == S_IDLE) ? {i_in_data.pos_y, i_in_data.pos_x}
                                          : {tap_py[POS_W-1:0], tap_px[POS_W-1:0]};

    rgbkf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata ({i_in_data.pixel_red, i_in_data.pixel_green, i_in_data.pixel_blue}),
        .o_rdata (mem_rdata)
    );

    // Accumulator control; read data arrives in the cycle after its tap.
    assign acc_ctrl.clear  = in_accept && in_inside && (i_in_data.kind == KIND_FILTER);
    assign acc_ctrl.add    = r_rd_ok;
    assign acc_ctrl.blur   = (r_mode == MODE_BLUR);
    assign acc_ctrl.weight = r_rd_weight;

    rgbkf_acc u_acc (
        .i_clk    (i_clk),
        .i_ctrl   (acc_ctrl),
        .i_pixel  (mem_rdata),
        .o_result (acc_result)
    );

    assign out_free = !r_out_valid || !i_out_stall;

    // Sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_ok     <= 1'b0;
            r_out_valid <= 1'b0;
            r_tap       <= '0;
        end else begin
            r_rd_ok     <= (r_state == S_READ) && tap_ok;
            r_rd_weight <= tap_w;
            // In the finish state a taken result is replaced by the new one below.
            if (r_out_valid && !i_out_stall && (r_state != S_FINISH)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (acc_ctrl.clear) begin
                        r_x     <= i_in_data.pos_x;
                        r_y     <= i_in_data.pos_y;
                        r_mode  <= r_filter_mode;
                        r_tap   <= '0;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_tap <= r_tap + TAP_W'(1);
                    if (r_tap == LAST_TAP) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (out_free) begin
                        r_out_valid               <= 1'b1;
                        r_out_data.out_x          <= r_x;
                        r_out_data.out_y          <= r_y;
                        r_out_data.filtered_red   <= acc_result[2*CH_W +: CH_W];
                        r_out_data.filtered_green <= acc_result[CH_W +: CH_W];
                        r_out_data.filtered_blue  <= acc_result[0 +: CH_W];
                        r_state                   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

// ===== design/rgbkf_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgbkf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  wire  logic                     i_clk,
    input  wire  logic                     i_we,
    input  wire  logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire  logic [WIDTH-1:0]         i_wdata,
    output logic       [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write on enable, otherwise read the addressed entry.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== design/rgbkf_acc.sv =====
// ----------------------------------------------------------------------------
// RGB 3x3 kernel filter accumulator
// Weights one pixel per cycle into three channel sums and saturates them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgbkf_acc
    import rgbkf_pkg::*;
(
    input  wire  logic             i_clk,
    input  wire  t_acc_ctrl        i_ctrl,
    input  wire  logic [PIX_W-1:0] i_pixel,
    output logic       [PIX_W-1:0] o_result
);

    logic signed [ACC_W-1:0] r_sum [3];
    logic signed [ACC_W-1:0] n_sum [3];
    logic signed [ACC_W-1:0] weight_ext;

    assign weight_ext = ACC_W'(i_ctrl.weight);

    // Multiply each channel by the tap weight and add.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            logic signed [ACC_W-1:0] chan;
            chan     = $signed({{(ACC_W-CH_W){1'b0}}, i_pixel[(2-c)*CH_W +: CH_W]});
            n_sum[c] = r_sum[c] + weight_ext * chan;
        end
    end

    // Sums restart on a new filter request and take in each valid tap.
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            if (i_ctrl.clear) begin
                r_sum[c] <= '0;
            end else if (i_ctrl.add) begin
                r_sum[c] <= n_sum[c];
            end
        end
    end

    // Blur divides by sixteen (the sum is never negative), then clamp to a byte.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            logic signed [ACC_W-1:0] val;
            val = i_ctrl.blur ? (r_sum[c] >>> BLUR_SHIFT) : r_sum[c];
            if (val < 0) begin
                o_result[(2-c)*CH_W +: CH_W] = '0;
            end else if (val > ACC_W'(255)) begin
                o_result[(2-c)*CH_W +: CH_W] = '1;
            end else begin
                o_result[(2-c)*CH_W +: CH_W] = val[CH_W-1:0];
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/rgbkf_checker.sv =====
// ----------------------------------------------------------------------------
// RGB 3x3 kernel filter checker
// Port-level assertions on the filter core, attached by a bind statement.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgbkf_checker
    import rgbkf_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic                 o_in_stall,
    input  wire t_in_req              i_in_data,
    input  wire logic                 o_out_valid,
    input  wire logic                 i_out_stall,
    input  wire t_out_res             o_out_data
);

    logic load_accept;

    assign load_accept = i_in_valid && !o_in_stall && (i_in_data.kind == KIND_LOAD);

    // A result that is held back keeps its valid and its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // A load never blocks the next request.
    a_load_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_accept |=> !o_in_stall)
        else $error("input stalled after a load");

    // A load never produces a result.
    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_accept |=> !$rose(o_out_valid))
        else $error("result appeared after a load");

    // A result only appears at the end of a filter walk.
    a_result_after_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without a filter walk");

    // Reset leaves the block empty and ready.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not idle after reset");

endmodule

bind rgb_3x3_kernel_filter_core rgbkf_checker u_checker (.*);

`default_nettype wire
